// File: design/oren_nayar_brdf_eval_unit_macros.svh
// Assertion helpers shared by the evaluation pipeline.
`ifndef OREN_NAYAR_BRDF_EVAL_UNIT_MACROS_SVH
`define OREN_NAYAR_BRDF_EVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ONB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("onb: implication check failed");
`define ONB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("onb: next-cycle check failed");
`else
`define ONB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ONB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/onb_pkg.sv
`default_nettype none

package onb_pkg;

  localparam int DirW        = 16;
  localparam int DirFracBits = 14;
  localparam int SineW       = DirFracBits + 1;
  localparam int RadW        = 2 * DirFracBits + 1;
  localparam int SqW         = 2 * DirW - 1;
  localparam int TanW        = DirFracBits + 4;
  localparam int TanShW      = TanW - DirFracBits;
  localparam int SqStages    = SineW;
  localparam int DivStages   = TanW;

  localparam int CfgW        = 16;
  localparam int EpsW        = 15;
  localparam int CfgIdxW     = 3;
  localparam int OutW        = 20;

  localparam int TermW       = TanW + 1;
  localparam int InnerFullW  = CfgW + TermW + 1;
  localparam int InnerShift  = DirFracBits - 5;
  localparam int InnerW      = InnerFullW - InnerShift;
  localparam int AlbShift    = 19;
  localparam int ChanW       = CfgW + InnerW - AlbShift;
  localparam int InvPiW      = 31;
  localparam int InvPiShift  = 32;
  localparam int ScaledW     = ChanW + InvPiW - InvPiShift;

  localparam int NumChan     = 3;
  localparam int NumUnit     = 4;

  localparam logic [InvPiW-1:0] InvPiQ32 = 31'd1367130551;
  localparam logic [OutW-1:0]   OutMax   = '1;
  localparam logic [TanW-1:0]   TanMax   = '1;
  localparam logic [SineW-1:0]  OneQ     = SineW'(1) << DirFracBits;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALB_RED   = 3'd0,
    REG_ALB_GREEN = 3'd1,
    REG_ALB_BLUE  = 3'd2,
    REG_COEF_A    = 3'd3,
    REG_COEF_B    = 3'd4,
    REG_SINE_EPS  = 3'd5
  } onb_reg_e;

  // carried alongside the square-root stages
  typedef struct packed {
    logic signed [DirW-1:0] ox;
    logic signed [DirW-1:0] oz;
    logic signed [DirW-1:0] ix;
    logic signed [DirW-1:0] iz;
    logic [DirW-1:0]        aoy;
    logic [DirW-1:0]        aiy;
  } onb_sq_side_t;

  // carried alongside the divider stages
  typedef struct packed {
    logic [SineW-1:0]   sin_alpha;
    logic               gate;
    logic [NumUnit-1:0] neg;
  } onb_dv_side_t;

endpackage

`default_nettype wire

// File: design/onb_sqrt_pipe.sv
`default_nettype none
`include "oren_nayar_brdf_eval_unit_macros.svh"

// Pipelined integer square root, one result bit per stage.
module onb_sqrt_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [onb_pkg::RadW-1:0]   rad_i,
  output logic                       vld_o,
  output logic [onb_pkg::SineW-1:0]  root_o
);
  import onb_pkg::*;

  localparam int RemW = SineW + 3;
  localparam int PadW = 2 * SineW;

  logic             vld_q  [SqStages];
  logic [SineW-1:0] root_q [SqStages];
  logic [RemW-1:0]  rem_q  [SqStages];
  logic [PadW-1:0]  rad_q  [SqStages];

  for (genvar s = 0; s < SqStages; s++) begin : g_step
    localparam int K = SqStages - 1 - s;
    logic             vld_p;
    logic [SineW-1:0] root_p;
    logic [RemW-1:0]  rem_p;
    logic [PadW-1:0]  rad_p;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;

    if (s == 0) begin : g_first
      assign vld_p  = vld_i;
      assign root_p = '0;
      assign rem_p  = '0;
      assign rad_p  = PadW'(rad_i);
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign root_p = root_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign rad_p  = rad_q[s-1];
    end

    assign rem_sh = {rem_p[RemW-3:0], rad_p[2*K+1 -: 2]};
    assign trial  = RemW'({root_p, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s] <= rad_p;
        if (rem_sh >= trial) begin
          rem_q[s]  <= rem_sh - trial;
          root_q[s] <= {root_p[SineW-2:0], 1'b1};
        end else begin
          rem_q[s]  <= rem_sh;
          root_q[s] <= {root_p[SineW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[SqStages-1];
  assign root_o = root_q[SqStages-1];

  // leftover must stay below the next square
  `ONB_ASSERT_IMP(a_sqrt_rem, clk_i, rst_ni, vld_q[SqStages-1], rem_q[SqStages-1] <= (RemW'(root_q[SqStages-1]) << 1))

endmodule

`default_nettype wire

// File: design/onb_div_pipe.sv
`default_nettype none
`include "oren_nayar_brdf_eval_unit_macros.svh"

// Pipelined restoring divider: (mag << DirFracBits) / den, one quotient bit per stage.
// over_o flags a quotient that does not fit in TanW bits (den of zero included).
module onb_div_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [onb_pkg::DirW-1:0]  mag_i,
  input  logic [onb_pkg::DirW-1:0]  den_i,
  output logic                      vld_o,
  output logic [onb_pkg::TanW-1:0]  quo_o,
  output logic                      over_o
);
  import onb_pkg::*;

  localparam int RemW = DirW + 1;

  logic              vld_q  [DivStages];
  logic [TanW-1:0]   quo_q  [DivStages];
  logic [RemW-1:0]   rem_q  [DivStages];
  logic [DirW-1:0]   den_q  [DivStages];
  logic [TanShW-1:0] mlo_q  [DivStages];
  logic              over_q [DivStages];

  logic over_in;
  assign over_in = ({{TanShW{1'b0}}, mag_i} >= {den_i, {TanShW{1'b0}}});

  for (genvar s = 0; s < DivStages; s++) begin : g_step
    localparam int K = DivStages - 1 - s;
    logic              vld_p;
    logic [TanW-1:0]   quo_p;
    logic [RemW-1:0]   rem_p;
    logic [DirW-1:0]   den_p;
    logic [TanShW-1:0] mlo_p;
    logic              over_p;
    logic              bit_in;
    logic [RemW-1:0]   rem_sh;
    logic [RemW-1:0]   den_x;

    if (s == 0) begin : g_first
      assign vld_p  = vld_i;
      assign quo_p  = '0;
      assign rem_p  = RemW'(mag_i[DirW-1:TanShW]);
      assign den_p  = den_i;
      assign mlo_p  = mag_i[TanShW-1:0];
      assign over_p = over_in;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign quo_p  = quo_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign den_p  = den_q[s-1];
      assign mlo_p  = mlo_q[s-1];
      assign over_p = over_q[s-1];
    end

    if (K >= DirFracBits) begin : g_mag_bit
      assign bit_in = mlo_p[K-DirFracBits];
    end else begin : g_zero_bit
      assign bit_in = 1'b0;
    end

    assign rem_sh = {rem_p[RemW-2:0], bit_in};
    assign den_x  = {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_p;
        mlo_q[s]  <= mlo_p;
        over_q[s] <= over_p;
        if (rem_sh >= den_x) begin
          rem_q[s] <= rem_sh - den_x;
          quo_q[s] <= {quo_p[TanW-2:0], 1'b1};
        end else begin
          rem_q[s] <= rem_sh;
          quo_q[s] <= {quo_p[TanW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[DivStages-1];
  assign quo_o  = quo_q[DivStages-1];
  assign over_o = over_q[DivStages-1];

  // a quotient in range leaves a remainder below the divisor
  `ONB_ASSERT_IMP(a_div_rem, clk_i, rst_ni, vld_q[DivStages-1] && !over_q[DivStages-1], rem_q[DivStages-1] < {1'b0, den_q[DivStages-1]})

endmodule

`default_nettype wire

// File: design/oren_nayar_brdf_eval_unit.sv
// Channel   Dir  Handshake             Payload
// input     in   in_valid_i/in_stall_o  out_x_i out_y_i out_z_i in_x_i in_y_i in_z_i
// result    out  out_valid_o/out_stall_i refl_red_o refl_green_o refl_blue_o saturated_o
// config    in   cfg_we_i               cfg_idx_i cfg_wdata_i
//
// One direction pair enters per cycle while in_stall_o is low.
// The pipeline is made of the two pipelined square roots (15 stages) and the
// five pipelined dividers (18 stages), plus 10 register stages of arithmetic.
// rst_ni clears all valid bits and restores the register defaults.
// A stalled result freezes the whole pipeline; bubbles ahead of it still advance
// only when the output register is free or being taken.
`default_nettype none
`include "oren_nayar_brdf_eval_unit_macros.svh"

module oren_nayar_brdf_eval_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // direction pairs
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [onb_pkg::DirW-1:0] out_x_i,
  input  logic signed [onb_pkg::DirW-1:0] out_y_i,
  input  logic signed [onb_pkg::DirW-1:0] out_z_i,
  input  logic signed [onb_pkg::DirW-1:0] in_x_i,
  input  logic signed [onb_pkg::DirW-1:0] in_y_i,
  input  logic signed [onb_pkg::DirW-1:0] in_z_i,
  // reflectance results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [onb_pkg::OutW-1:0]       refl_red_o,
  output logic [onb_pkg::OutW-1:0]       refl_green_o,
  output logic [onb_pkg::OutW-1:0]       refl_blue_o,
  output logic                           saturated_o,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [onb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [onb_pkg::CfgW-1:0]       cfg_wdata_i
);
  import onb_pkg::*;

  function automatic logic [DirW-1:0] mag16(input logic signed [DirW-1:0] v);
    return v[DirW-1] ? DirW'(-v) : DirW'(v);
  endfunction

  // ---------------------------------------------------------------- registers
  logic [CfgW-1:0] alb_q [NumChan];
  logic [CfgW-1:0] coef_a_q;
  logic [CfgW-1:0] coef_b_q;
  logic [EpsW-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alb_q[0] <= CfgW'(32768);
      alb_q[1] <= CfgW'(32768);
      alb_q[2] <= CfgW'(32768);
      coef_a_q <= CfgW'(32768);
      coef_b_q <= '0;
      eps_q    <= EpsW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALB_RED:   alb_q[0] <= cfg_wdata_i;
        REG_ALB_GREEN: alb_q[1] <= cfg_wdata_i;
        REG_ALB_BLUE:  alb_q[2] <= cfg_wdata_i;
        REG_COEF_A:    coef_a_q <= cfg_wdata_i;
        REG_COEF_B:    coef_b_q <= cfg_wdata_i;
        REG_SINE_EPS:  eps_q    <= cfg_wdata_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // Every stage advances together; hold everything while a result waits.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage B: squares
  logic signed [2*DirW-1:0] yo_sq, yi_sq;
  assign yo_sq = out_y_i * out_y_i;
  assign yi_sq = in_y_i * in_y_i;

  logic                b_vld_q;
  onb_sq_side_t        b_side_q;
  logic [SqW-1:0]      b_yo2_q, b_yi2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q.ox  <= out_x_i;
      b_side_q.oz  <= out_z_i;
      b_side_q.ix  <= in_x_i;
      b_side_q.iz  <= in_z_i;
      b_side_q.aoy <= mag16(out_y_i);
      b_side_q.aiy <= mag16(in_y_i);
      b_yo2_q      <= SqW'($unsigned(yo_sq));
      b_yi2_q      <= SqW'($unsigned(yi_sq));
    end
  end

  // ---------------------------------------------------------------- square roots
  localparam logic [SqW-1:0] One2 = SqW'(1) << (2 * DirFracBits);

  logic [RadW-1:0] rad_o, rad_i;
  assign rad_o = (b_yo2_q >= One2) ? '0 : RadW'(One2 - b_yo2_q);
  assign rad_i = (b_yi2_q >= One2) ? '0 : RadW'(One2 - b_yi2_q);

  logic             sq_vld_o, sq_vld_i;
  logic [SineW-1:0] sine_o, sine_i;

  onb_sqrt_pipe u_sqrt_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .rad_i  (rad_o),
    .vld_o  (sq_vld_o),
    .root_o (sine_o)
  );

  onb_sqrt_pipe u_sqrt_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .rad_i  (rad_i),
    .vld_o  (sq_vld_i),
    .root_o (sine_i)
  );

  onb_sq_side_t sq_side_q [SqStages];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_side_q[0] <= b_side_q;
      for (int i = 1; i < SqStages; i++) begin
        sq_side_q[i] <= sq_side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage D: select alpha/beta
  onb_sq_side_t sd;
  logic         sel_in_beta;
  assign sd          = sq_side_q[SqStages-1];
  // |out_y| < |in_y|: outgoing angle is the larger one
  assign sel_in_beta = (sd.aoy < sd.aiy);

  logic                d_vld_q;
  logic [SineW-1:0]    d_sa_q, d_sb_q, d_si_q, d_so_q;
  logic [DirW-1:0]     d_cb_q;
  logic                d_gate_q;
  logic [DirW-1:0]     d_mag_q [NumUnit];
  logic [NumUnit-1:0]  d_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= sq_vld_o && sq_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sa_q     <= sel_in_beta ? sine_o : sine_i;
      d_sb_q     <= sel_in_beta ? sine_i : sine_o;
      d_cb_q     <= sel_in_beta ? sd.aiy : sd.aoy;
      d_si_q     <= sine_i;
      d_so_q     <= sine_o;
      d_gate_q   <= (sine_i > eps_q) && (sine_o > eps_q);
      // ratios: x / sine and -z / sine for each direction
      d_mag_q[0] <= mag16(sd.ix);
      d_mag_q[1] <= mag16(sd.iz);
      d_mag_q[2] <= mag16(sd.ox);
      d_mag_q[3] <= mag16(sd.oz);
      d_neg_q[0] <= sd.ix[DirW-1];
      d_neg_q[1] <= !sd.iz[DirW-1] && (sd.iz != '0);
      d_neg_q[2] <= sd.ox[DirW-1];
      d_neg_q[3] <= !sd.oz[DirW-1] && (sd.oz != '0);
    end
  end

  // ---------------------------------------------------------------- dividers
  logic            tan_vld, tan_over;
  logic [TanW-1:0] tan_quo;

  onb_div_pipe u_div_tan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld_q),
    .mag_i  (DirW'(d_sb_q)),
    .den_i  (d_cb_q),
    .vld_o  (tan_vld),
    .quo_o  (tan_quo),
    .over_o (tan_over)
  );

  logic [NumUnit-1:0] u_vld, u_over;
  logic [TanW-1:0]    u_quo [NumUnit];

  for (genvar u = 0; u < NumUnit; u++) begin : g_unit
    logic [DirW-1:0] den;
    assign den = (u < 2) ? DirW'(d_si_q) : DirW'(d_so_q);

    onb_div_pipe u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (d_vld_q),
      .mag_i  (d_mag_q[u]),
      .den_i  (den),
      .vld_o  (u_vld[u]),
      .quo_o  (u_quo[u]),
      .over_o (u_over[u])
    );
  end

  onb_dv_side_t dv_side_q [DivStages];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side_q[0].sin_alpha <= d_sa_q;
      dv_side_q[0].gate      <= d_gate_q;
      dv_side_q[0].neg       <= d_neg_q;
      for (int i = 1; i < DivStages; i++) begin
        dv_side_q[i] <= dv_side_q[i-1];
      end
    end
  end

  onb_dv_side_t dv;
  assign dv = dv_side_q[DivStages-1];

  // ---------------------------------------------------------------- stage E: clamp ratios
  logic signed [DirW-1:0] u_val [NumUnit];

  always_comb begin
    for (int u = 0; u < NumUnit; u++) begin
      logic [DirW-1:0] mag;
      mag = (u_over[u] || (u_quo[u] > TanW'(OneQ))) ? DirW'(OneQ) : DirW'(u_quo[u]);
      u_val[u] = dv.neg[u] ? $signed(DirW'(-mag)) : $signed(mag);
    end
  end

  logic                   e_vld_q;
  logic signed [DirW-1:0] e_u_q [NumUnit];
  logic [TanW-1:0]        e_tan_q;
  logic                   e_tsat_q;
  logic [SineW-1:0]       e_sa_q;
  logic                   e_gate_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int u = 0; u < NumUnit; u++) begin
        e_u_q[u] <= u_val[u];
      end
      e_tan_q  <= tan_over ? TanMax : tan_quo;
      e_tsat_q <= tan_over;
      e_sa_q   <= dv.sin_alpha;
      e_gate_q <= dv.gate;
    end
  end

  // ---------------------------------------------------------------- stage F: azimuth products
  logic signed [2*DirW-1:0] p_cos, p_sin;
  assign p_cos = e_u_q[0] * e_u_q[2];
  assign p_sin = e_u_q[1] * e_u_q[3];

  logic                     f_vld_q;
  logic signed [2*DirW-1:0] f_pc_q, f_ps_q;
  logic [TanW-1:0]          f_tan_q;
  logic                     f_tsat_q;
  logic [SineW-1:0]         f_sa_q;
  logic                     f_gate_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pc_q   <= p_cos;
      f_ps_q   <= p_sin;
      f_tan_q  <= e_tan_q;
      f_tsat_q <= e_tsat_q;
      f_sa_q   <= e_sa_q;
      f_gate_q <= e_gate_q;
    end
  end

  // ---------------------------------------------------------------- stage G: cos(phi_i - phi_o)
  logic signed [2*DirW:0]          dsum;
  logic [2*DirW-DirFracBits:0]     dsh;
  logic [SineW-1:0]                dcos;
  assign dsum = f_pc_q + f_ps_q;
  assign dsh  = $unsigned(dsum[2*DirW:DirFracBits]);

  always_comb begin
    if (!f_gate_q || (dsum <= 0)) begin
      dcos = '0;
    end else if (dsh > (2*DirW-DirFracBits+1)'(OneQ)) begin
      dcos = OneQ;
    end else begin
      dcos = dsh[SineW-1:0];
    end
  end

  logic             g_vld_q;
  logic [SineW-1:0] g_dcos_q, g_sa_q;
  logic [TanW-1:0]  g_tan_q;
  logic             g_tsat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_dcos_q <= dcos;
      g_sa_q   <= f_sa_q;
      g_tan_q  <= f_tan_q;
      g_tsat_q <= f_tsat_q;
    end
  end

  // ---------------------------------------------------------------- stage H: dcos * sin(alpha)
  logic [2*SineW-1:0] p_ds;
  assign p_ds = g_dcos_q * g_sa_q;

  logic             h_vld_q;
  logic [SineW-1:0] h_m1_q;
  logic [TanW-1:0]  h_tan_q;
  logic             h_tsat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_m1_q   <= p_ds[DirFracBits +: SineW];
      h_tan_q  <= g_tan_q;
      h_tsat_q <= g_tsat_q;
    end
  end

  // ---------------------------------------------------------------- stage I: * tan(beta)
  logic [SineW+TanW-1:0] p_mt;
  assign p_mt = h_m1_q * h_tan_q;

  logic             i_vld_q;
  logic [TermW-1:0] i_term_q;
  logic             i_tsat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_term_q <= p_mt[DirFracBits +: TermW];
      i_tsat_q <= h_tsat_q;
    end
  end

  // ---------------------------------------------------------------- stage J: A + B * term
  logic [CfgW+TermW-1:0] p_bt;
  logic [InnerFullW-1:0] inner;
  assign p_bt  = coef_b_q * i_term_q;
  assign inner = (InnerFullW'(coef_a_q) << DirFracBits) + InnerFullW'(p_bt);

  logic              j_vld_q;
  logic [InnerW-1:0] j_inner_q;
  logic              j_tsat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_inner_q <= inner[InnerFullW-1:InnerShift];
      j_tsat_q  <= i_tsat_q;
    end
  end

  // ---------------------------------------------------------------- stage K: albedo
  logic [CfgW+InnerW-1:0] p_alb [NumChan];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      p_alb[c] = alb_q[c] * j_inner_q;
    end
  end

  logic             k_vld_q;
  logic [ChanW-1:0] k_ch_q [NumChan];
  logic             k_tsat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumChan; c++) begin
        k_ch_q[c] <= p_alb[c][AlbShift +: ChanW];
      end
      k_tsat_q <= j_tsat_q;
    end
  end

  // ---------------------------------------------------------------- stage L: 1/pi, saturate
  logic [ChanW+InvPiW-1:0] p_pi  [NumChan];
  logic [ScaledW-1:0]      scl   [NumChan];
  logic [OutW-1:0]         chv   [NumChan];
  logic [NumChan-1:0]      ch_sat;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      p_pi[c]   = k_ch_q[c] * InvPiQ32;
      scl[c]    = p_pi[c][InvPiShift +: ScaledW];
      ch_sat[c] = (scl[c] > ScaledW'(OutMax));
      chv[c]    = ch_sat[c] ? OutMax : scl[c][OutW-1:0];
    end
  end

  logic [OutW-1:0] refl_q [NumChan];
  logic            sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumChan; c++) begin
        refl_q[c] <= chv[c];
      end
      sat_q <= k_tsat_q || (ch_sat != '0);
    end
  end

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q     <= 1'b0;
      f_vld_q     <= 1'b0;
      g_vld_q     <= 1'b0;
      h_vld_q     <= 1'b0;
      i_vld_q     <= 1'b0;
      j_vld_q     <= 1'b0;
      k_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      e_vld_q     <= tan_vld && (u_vld == '1);
      f_vld_q     <= e_vld_q;
      g_vld_q     <= f_vld_q;
      h_vld_q     <= g_vld_q;
      i_vld_q     <= h_vld_q;
      j_vld_q     <= i_vld_q;
      k_vld_q     <= j_vld_q;
      out_valid_q <= k_vld_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign refl_red_o   = refl_q[0];
  assign refl_green_o = refl_q[1];
  assign refl_blue_o  = refl_q[2];
  assign saturated_o  = sat_q;

  // a frozen pipeline keeps every valid bit in place
  `ONB_ASSERT_NXT(a_hold_mid, clk_i, rst_ni, !en, $stable(d_vld_q) && $stable(g_vld_q) && $stable(k_vld_q))

endmodule

`default_nettype wire

// File: test/oren_nayar_brdf_eval_unit_test.sv
`default_nettype none

// Scoreboard: predicts the reflectance of each accepted direction pair and
// compares results in order.
class refl_scoreboard;
  typedef struct packed {
    logic [19:0] red;
    logic [19:0] green;
    logic [19:0] blue;
    logic        sat;
  } refl_t;

  refl_t       pending[$];
  logic [15:0] alb_r = 16'd32768, alb_g = 16'd32768, alb_b = 16'd32768;
  logic [15:0] coef_a = 16'd32768, coef_b = 16'd0;
  logic [14:0] sine_eps = 15'd16;
  int          n_err;

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      onb_pkg::REG_ALB_RED:   alb_r = val;
      onb_pkg::REG_ALB_GREEN: alb_g = val;
      onb_pkg::REG_ALB_BLUE:  alb_b = val;
      onb_pkg::REG_COEF_A:    coef_a = val;
      onb_pkg::REG_COEF_B:    coef_b = val;
      onb_pkg::REG_SINE_EPS:  sine_eps = val[14:0];
      default: ;
    endcase
  endfunction

  function longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function longint unsigned sine_of(longint y);
    longint unsigned y2;
    y2 = y * y;
    return (y2 >= (64'd1 << 28)) ? 0 : root((64'd1 << 28) - y2);
  endfunction

  function longint ratio(longint v, longint unsigned s);
    longint unsigned q;
    q = ((v < 0 ? -v : v) << 14) / s;
    if (q > 16384) q = 16384;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function longint unsigned scale(logic [15:0] alb, longint unsigned inner, ref bit sat);
    longint unsigned t;
    t = (longint'(alb) * inner) >> 19;
    t = (t * 64'd1367130551) >> 32;
    if (t > 1048575) begin
      t = 1048575;
      sat = 1;
    end
    return t;
  endfunction

  function void note_request(logic signed [15:0] d[6]);
    longint ox, oy, oz, ix, iy, iz, dd, ci, co, sni, sno;
    longint unsigned so, si, aoy, aiy, sa, sb, cb, tanb, dcos, term, inner;
    bit sat;
    refl_t e;
    ox = d[0]; oy = d[1]; oz = d[2]; ix = d[3]; iy = d[4]; iz = d[5];
    sat = 0;
    dcos = 0;
    so = sine_of(oy);
    si = sine_of(iy);
    aoy = oy < 0 ? -oy : oy;
    aiy = iy < 0 ? -iy : iy;
    if (aoy < aiy) begin
      sa = so; sb = si; cb = aiy;
    end else begin
      sa = si; sb = so; cb = aoy;
    end
    if (cb == 0) begin
      tanb = 262143; sat = 1;
    end else begin
      tanb = (sb << 14) / cb;
      if (tanb > 262143) begin
        tanb = 262143; sat = 1;
      end
    end
    if (si > sine_eps && so > sine_eps) begin
      ci = ratio(ix, si); sni = ratio(-iz, si);
      co = ratio(ox, so); sno = ratio(-oz, so);
      dd = ci * co + sni * sno;
      if (dd > 0) begin
        dcos = dd >> 14;
        if (dcos > 16384) dcos = 16384;
      end
    end
    term = (((dcos * sa) >> 14) * tanb) >> 14;
    inner = ((longint'(coef_a) << 14) + longint'(coef_b) * term) >> 9;
    e.red = 20'(scale(alb_r, inner, sat));
    e.green = 20'(scale(alb_g, inner, sat));
    e.blue = 20'(scale(alb_b, inner, sat));
    e.sat = sat;
    pending.push_back(e);
  endfunction

  function void check_result(refl_t got);
    refl_t e;
    if (pending.size() == 0) begin
      n_err++;
      if (n_err <= 10) $display("unexpected result %h", got);
      return;
    end
    e = pending.pop_front();
    if (e !== got) begin
      n_err++;
      if (n_err <= 10)
        $display("mismatch: exp r=%0d g=%0d b=%0d s=%0b got r=%0d g=%0d b=%0d s=%0b",
                 e.red, e.green, e.blue, e.sat, got.red, got.green, got.blue, got.sat);
    end
  endfunction
endclass

module oren_nayar_brdf_eval_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import onb_pkg::*;

  localparam int Latency = 43;
  localparam int CycleLimit = 400000;
  // index outside the register list
  localparam logic [2:0] RegUnused = 3'd7;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 1'b0, saturated;
  logic signed [15:0] d_ox = 0, d_oy = 0, d_oz = 0, d_ix = 0, d_iy = 0, d_iz = 0;
  logic [19:0] refl_r, refl_g, refl_b;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = 0;
  logic [15:0] cfg_wdata = 0;
  refl_scoreboard sb;
  int cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  oren_nayar_brdf_eval_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .out_x_i(d_ox), .out_y_i(d_oy), .out_z_i(d_oz),
    .in_x_i(d_ix), .in_y_i(d_iy), .in_z_i(d_iz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .refl_red_o(refl_r), .refl_green_o(refl_g), .refl_blue_o(refl_b),
    .saturated_o(saturated),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // Time out if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample results on the edge; check only accepted ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({refl_r, refl_g, refl_b, saturated});
  end

  // Receiver: stall for a random number of cycles per result, sometimes none.
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Write one register; caller guarantees the pipeline is empty.
  task automatic write_reg(onb_reg_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one request, holding it until accepted; gap drawn per item.
  task automatic send_pair(logic signed [15:0] d[6], bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {d_ox, d_oy, d_oz, d_ix, d_iy, d_iz} <= {d[0], d[1], d[2], d[3], d[4], d[5]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(d);
  endtask

  // Drain the pipeline before touching registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Random unit-ish direction: pick y, then x/z roughly on the circle.
  function automatic void rand_dir(output logic signed [15:0] x, y, z);
    real ry, s, ph;
    ry = ($urandom_range(0, 20000) / 10000.0) - 1.0;
    s = $sqrt(1.0 - ry * ry);
    ph = $urandom_range(0, 62831) / 10000.0;
    y = 16'($rtoi(ry * 16384.0));
    x = 16'($rtoi(s * $cos(ph) * 16384.0));
    z = 16'($rtoi(s * $sin(ph) * 16384.0));
  endfunction

  task automatic random_phase(int n);
    logic signed [15:0] d[6];
    bit burst;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        foreach (d[j]) d[j] = rand_comp();
      end else begin
        rand_dir(d[0], d[1], d[2]);
        rand_dir(d[3], d[4], d[5]);
      end
      burst = (k % 100) < 30;
      send_pair(d, burst);
    end
  endtask

  initial begin
    logic signed [15:0] d[6];
    logic signed [15:0] dirs[12][6];
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, equal cosines, zero normal, small sine, non-unit.
    dirs = '{
      '{0, 16384, 0, 0, 16384, 0},
      '{16384, 0, 0, 16384, 0, 0},
      '{11585, 11585, 0, 11585, 11585, 0},
      '{0, 8192, 14189, 0, 8192, 14189},
      '{-16384, 0, 0, 16384, 0, 0},
      '{11585, 11585, 0, 0, 4096, 15863},
      '{-32768, -32768, -32768, 32767, 32767, 32767},
      '{32767, -32768, 0, -32768, 32767, 16384},
      '{0, 16383, 1, 1, -16383, 0},
      '{16384, 0, 0, 0, 16384, 0},
      '{-1, -1, -1, -1, -1, -1},
      '{-16384, -8000, 5000, 9000, 10000, -7000}
    };
    foreach (dirs[k]) begin
      foreach (d[j]) d[j] = dirs[k][j];
      send_pair(d, 0);
    end
    drain();

    // Rough surface, full albedo: large channels and saturation.
    write_reg(REG_COEF_B, 16'd32768);
    write_reg(REG_SINE_EPS, 16'd0);
    write_reg(REG_COEF_A, 16'd32768);
    foreach (dirs[k]) begin
      foreach (d[j]) d[j] = dirs[k][j];
      send_pair(d, 1);
    end
    random_phase(250);
    drain();

    // Zero red albedo and A, huge epsilon; unknown index must be ignored.
    write_reg(REG_ALB_RED, 16'd0);
    write_reg(REG_ALB_GREEN, 16'd65535);
    write_reg(REG_ALB_BLUE, 16'd12345);
    write_reg(REG_COEF_A, 16'd0);
    write_reg(REG_SINE_EPS, 16'd16384);
    cfg_we <= 1'b1;
    cfg_idx <= RegUnused;
    cfg_wdata <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    random_phase(200);
    drain();

    // Random settings across all registers.
    repeat (3) begin
      write_reg(REG_ALB_RED, 16'($urandom));
      write_reg(REG_ALB_GREEN, 16'($urandom_range(0, 32768)));
      write_reg(REG_ALB_BLUE, 16'($urandom_range(0, 32768)));
      write_reg(REG_COEF_A, 16'($urandom));
      write_reg(REG_COEF_B, 16'($urandom));
      write_reg(REG_SINE_EPS, 16'($urandom_range(0, 32767)));
      random_phase(150);
      drain();
    end

    repeat (Latency + 10) @(posedge clk);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/onb_pkg.sv
design/onb_sqrt_pipe.sv
design/onb_div_pipe.sv
design/oren_nayar_brdf_eval_unit.sv
test/oren_nayar_brdf_eval_unit_test.sv
